// File: src/cwl_pkg.sv
// Shared constants, tables, types and helpers of the color wheel LED effect.
package cwl_pkg;

   // Ring and wheel geometry
   localparam int MAX_LEDS    = 16;
   localparam int WHEEL_STEPS = 30;
   localparam int SEG_RG      = WHEEL_STEPS / 3;
   localparam int SEG_GB      = SEG_RG * 2;
   localparam int SEG_STEP    = 255 / SEG_RG;

   localparam int PHASE_W   = $clog2(WHEEL_STEPS);
   localparam int OFF_W     = PHASE_W + 1;
   localparam int CNT_W     = 5;
   localparam int IDX_W     = 4;
   localparam int TIME_W    = 32;
   localparam int IVL_W     = 16;
   localparam int LVL_W     = 3;
   localparam int BYTE_W    = 8;
   localparam int PROD_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RING_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_ORDER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL   = 2'd3;

   localparam logic [LVL_W-1:0] LVL_MAX = 3'd4;

   // Reset values
   localparam logic [CNT_W-1:0] RST_RING_SIZE = 5'd16;
   localparam logic [LVL_W-1:0] RST_LEVEL     = 3'd4;
   localparam logic [IVL_W-1:0] RST_INTERVAL  = 16'd50;

   // Brightness table
   localparam logic [BYTE_W-1:0] BRIGHT_TABLE [0:4] = '{8'd0, 8'd80, 8'd120, 8'd160, 8'd200};

   // Per LED step of i*WHEEL_STEPS/n: quotient and remainder of WHEEL_STEPS/n
   localparam logic [PHASE_W-1:0] QUOT_TABLE [0:MAX_LEDS] = '{
      PHASE_W'(0),
      PHASE_W'(WHEEL_STEPS / 1),  PHASE_W'(WHEEL_STEPS / 2),  PHASE_W'(WHEEL_STEPS / 3),
      PHASE_W'(WHEEL_STEPS / 4),  PHASE_W'(WHEEL_STEPS / 5),  PHASE_W'(WHEEL_STEPS / 6),
      PHASE_W'(WHEEL_STEPS / 7),  PHASE_W'(WHEEL_STEPS / 8),  PHASE_W'(WHEEL_STEPS / 9),
      PHASE_W'(WHEEL_STEPS / 10), PHASE_W'(WHEEL_STEPS / 11), PHASE_W'(WHEEL_STEPS / 12),
      PHASE_W'(WHEEL_STEPS / 13), PHASE_W'(WHEEL_STEPS / 14), PHASE_W'(WHEEL_STEPS / 15),
      PHASE_W'(WHEEL_STEPS / 16)};
   localparam logic [CNT_W-1:0] REM_TABLE [0:MAX_LEDS] = '{
      CNT_W'(0),
      CNT_W'(WHEEL_STEPS % 1),  CNT_W'(WHEEL_STEPS % 2),  CNT_W'(WHEEL_STEPS % 3),
      CNT_W'(WHEEL_STEPS % 4),  CNT_W'(WHEEL_STEPS % 5),  CNT_W'(WHEEL_STEPS % 6),
      CNT_W'(WHEEL_STEPS % 7),  CNT_W'(WHEEL_STEPS % 8),  CNT_W'(WHEEL_STEPS % 9),
      CNT_W'(WHEEL_STEPS % 10), CNT_W'(WHEEL_STEPS % 11), CNT_W'(WHEEL_STEPS % 12),
      CNT_W'(WHEEL_STEPS % 13), CNT_W'(WHEEL_STEPS % 14), CNT_W'(WHEEL_STEPS % 15),
      CNT_W'(WHEEL_STEPS % 16)};

   // Controller to datapath commands
   typedef struct packed {
      logic idle;   // ready for a new event
      logic start;  // event accepted this cycle
      logic calc;   // compute scaled channels of the current LED
      logic emit;   // load the result register and advance
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic req_valid;
      logic pass;      // event spacing met
      logic empty;     // no LEDs configured
      logic last;      // current LED is the final one
      logic out_free;  // result register can take a new transaction
   } sts_type;

   // Rising edge of a gradient segment, saturating at full scale
   function automatic logic [BYTE_W-1:0] rise(input logic [OFF_W-1:0] k);
      logic [PROD_W-1:0] v;
      v = PROD_W'(k) * PROD_W'(SEG_STEP);
      return (v > PROD_W'(255)) ? 8'd255 : v[BYTE_W-1:0];
   endfunction

   // Falling edge of a gradient segment, saturating at zero
   function automatic logic [BYTE_W-1:0] fall(input logic [OFF_W-1:0] k);
      logic [PROD_W-1:0] v;
      v = PROD_W'(k) * PROD_W'(SEG_STEP);
      return (v > PROD_W'(255)) ? 8'd0 : (8'd255 - v[BYTE_W-1:0]);
   endfunction

   // Exact x/255 for x up to 255*255: (x + (x >> 8) + 1) >> 8
   function automatic logic [BYTE_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] t;
      t = {1'b0, x} + {9'd0, x[PROD_W-1:8]} + 17'd1;
      return t[PROD_W-1:8];
   endfunction

endpackage

// File: src/cwl_req_if.sv
// Rotation event channel.
interface cwl_req_if;
   import cwl_pkg::*;
   logic              valid;
   logic              ready;
   logic              spin_ccw;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, spin_ccw, now_ms, input ready);
   modport sink   (input valid, spin_ccw, now_ms, output ready);
endinterface

// File: src/cwl_rsp_if.sv
// Per LED color result channel.
interface cwl_rsp_if;
   import cwl_pkg::*;
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  led_index;
   logic [BYTE_W-1:0] wire_byte0;
   logic [BYTE_W-1:0] wire_byte1;
   logic [BYTE_W-1:0] wire_byte2;
   logic              last_led;

   modport source (output valid, led_index, wire_byte0, wire_byte1, wire_byte2, last_led,
                   input ready);
   modport sink   (input valid, led_index, wire_byte0, wire_byte1, wire_byte2, last_led,
                   output ready);
endinterface

// File: src/cwl_ctrl.sv
// Controller state machine: sequences event check and per LED computation.
module cwl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  cwl_pkg::sts_type sts,
   output cwl_pkg::cmd_type cmd
);
   import cwl_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (sts.req_valid) begin
               cmd.start = 1'b1;
               if (sts.pass && !sts.empty) state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.last ? ST_IDLE : ST_CALC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/cwl_dpath.sv
// Datapath: registers, phase and time state, gradient, scaling and result register.
module cwl_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [cwl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cwl_pkg::CSR_DAT_W-1:0]     csr_wdata,
   cwl_req_if.sink                           req_if,
   cwl_rsp_if.source                         rsp_if,
   input  cwl_pkg::cmd_type                  cmd,
   output cwl_pkg::sts_type                  sts
);
   import cwl_pkg::*;

   // Configuration registers
   logic [CNT_W-1:0]   ring_size_ff;
   logic               byte_order_ff;
   logic [LVL_W-1:0]   level_ff;
   logic [IVL_W-1:0]   interval_ff;

   // Event state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [TIME_W-1:0]  last_ms_ff;

   // Frame walk
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [PHASE_W-1:0] quot_ff;
   logic [CNT_W-1:0]   rem_ff;
   logic [PHASE_W-1:0] qstep_ff;
   logic [CNT_W-1:0]   rstep_ff;
   logic [BYTE_W-1:0]  lvl_ff;

   // Scaled channel products
   logic [PROD_W-1:0]  red_prod_ff, grn_prod_ff, blu_prod_ff;

   // Result register
   logic               rsp_valid_ff;
   logic [IDX_W-1:0]   rsp_index_ff;
   logic [BYTE_W-1:0]  rsp_b0_ff, rsp_b1_ff, rsp_b2_ff;
   logic               rsp_last_ff;

   logic [TIME_W-1:0]  elapsed;
   logic               pass;
   logic               is_last;
   logic [OFF_W-1:0]   off_sum;
   logic [OFF_W-1:0]   off;
   logic [BYTE_W-1:0]  red, grn, blu;
   logic [CNT_W:0]     rem_sum;
   logic               rem_wrap;
   logic [BYTE_W-1:0]  red_q, grn_q, blu_q;

   // Event spacing check with wrapping time
   assign elapsed = req_if.now_ms - last_ms_ff;
   assign pass    = elapsed >= {{(TIME_W-IVL_W){1'b0}}, interval_ff};

   // Phase step and clamped LED count
   always_comb begin
      if (req_if.spin_ccw) begin
         phase_in = (phase_ff < PHASE_W'(WHEEL_STEPS - 1)) ? phase_ff + 1'b1 : '0;
      end else begin
         phase_in = (phase_ff != '0) ? phase_ff - 1'b1 : PHASE_W'(WHEEL_STEPS - 1);
      end
      n_in = (ring_size_ff > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : ring_size_ff;
   end

   assign is_last = ({1'b0, idx_ff} + 5'd1) == n_ff;

   assign sts.req_valid = req_if.valid;
   assign sts.pass      = pass;
   assign sts.empty     = (n_in == '0);
   assign sts.last      = is_last;
   assign sts.out_free  = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready = cmd.idle;

   // Wheel offset and three-segment gradient
   always_comb begin
      off_sum = {1'b0, phase_ff} + {1'b0, quot_ff};
      off     = (off_sum >= OFF_W'(WHEEL_STEPS)) ? off_sum - OFF_W'(WHEEL_STEPS) : off_sum;
      if (off < OFF_W'(SEG_RG)) begin
         red = fall(off);
         grn = rise(off);
         blu = '0;
      end else if (off < OFF_W'(SEG_GB)) begin
         red = '0;
         grn = fall(off - OFF_W'(SEG_RG));
         blu = rise(off - OFF_W'(SEG_RG));
      end else begin
         red = rise(off - OFF_W'(SEG_GB));
         grn = '0;
         blu = fall(off - OFF_W'(SEG_GB));
      end
   end

   // Next quotient and remainder of idx*WHEEL_STEPS/n
   assign rem_sum  = {1'b0, rem_ff} + {1'b0, rstep_ff};
   assign rem_wrap = rem_sum >= {1'b0, n_ff};

   // Divide scaled channels by full scale
   assign red_q = div255(red_prod_ff);
   assign grn_q = div255(grn_prod_ff);
   assign blu_q = div255(blu_prod_ff);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff  <= RST_RING_SIZE;
         byte_order_ff <= 1'b0;
         level_ff      <= RST_LEVEL;
         interval_ff   <= RST_INTERVAL;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RING_SIZE:  ring_size_ff  <= csr_wdata[CNT_W-1:0];
            CSR_BYTE_ORDER: byte_order_ff <= csr_wdata[0];
            CSR_BRIGHTNESS: begin
               if (csr_wdata[LVL_W-1:0] <= LVL_MAX) level_ff <= csr_wdata[LVL_W-1:0];
            end
            CSR_INTERVAL:   interval_ff   <= csr_wdata[IVL_W-1:0];
            default: ;
         endcase
      end
   end

   // Event state: phase and time of last accepted event
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         last_ms_ff <= '0;
      end else if (cmd.start && pass) begin
         phase_ff   <= phase_in;
         last_ms_ff <= req_if.now_ms;
      end
   end

   // Frame walk registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         n_ff     <= n_in;
         idx_ff   <= '0;
         quot_ff  <= '0;
         rem_ff   <= '0;
         qstep_ff <= QUOT_TABLE[n_in];
         rstep_ff <= REM_TABLE[n_in];
         lvl_ff   <= BRIGHT_TABLE[level_ff];
      end else if (cmd.emit) begin
         idx_ff <= idx_ff + 1'b1;
         if (rem_wrap) begin
            rem_ff  <= CNT_W'(rem_sum - {1'b0, n_ff});
            quot_ff <= quot_ff + qstep_ff + 1'b1;
         end else begin
            rem_ff  <= rem_sum[CNT_W-1:0];
            quot_ff <= quot_ff + qstep_ff;
         end
      end
   end

   // Channel scaling products
   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         red_prod_ff <= {8'd0, red} * {8'd0, lvl_ff};
         grn_prod_ff <= {8'd0, grn} * {8'd0, lvl_ff};
         blu_prod_ff <= {8'd0, blu} * {8'd0, lvl_ff};
      end
   end

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload in wire order
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_index_ff <= idx_ff;
         rsp_b0_ff    <= byte_order_ff ? red_q : grn_q;
         rsp_b1_ff    <= byte_order_ff ? grn_q : red_q;
         rsp_b2_ff    <= blu_q;
         rsp_last_ff  <= is_last;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.led_index  = rsp_index_ff;
   assign rsp_if.wire_byte0 = rsp_b0_ff;
   assign rsp_if.wire_byte1 = rsp_b1_ff;
   assign rsp_if.wire_byte2 = rsp_b2_ff;
   assign rsp_if.last_led   = rsp_last_ff;

endmodule

// File: src/rotating_color_wheel_led_effect.sv
// Top level of the rotating color wheel LED effect.
//
// Usage:
//   req_if carries rotation events (spin_ccw, now_ms) with valid/ready.
//   An event arriving sooner than step_interval_ms after the last accepted
//   one is consumed and produces nothing. Otherwise the wheel phase steps
//   and one rsp_if transaction per LED follows, in index order, with
//   last_led set on the final LED. A ring of zero LEDs still steps the phase.
//   csr_we/csr_index/csr_wdata write the ring size, the wire byte order,
//   brightness_level and step_interval_ms; write only while idle.
// Sequence:
//   An accepted event starts a frame; each LED is computed by the channel
//   multiply into the product registers, then divided into the result register,
//   which waits until the previous result is taken. A dropped event leaves the
//   block idle. req_if.ready is high only between frames.
// Reset and stall:
//   Synchronous reset restores register defaults, phase 0 and last time 0.
//   While rsp_if.ready is low the result register holds and the frame pauses.
module rotating_color_wheel_led_effect (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [cwl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cwl_pkg::CSR_DAT_W-1:0] csr_wdata,
   cwl_req_if.sink                       req_if,
   cwl_rsp_if.source                     rsp_if
);
   import cwl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   cwl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // Datapath
   cwl_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// File: tb/sv/tb_rotating_color_wheel_led_effect.sv
// Self-checking testbench for the rotating color wheel LED effect.
`timescale 1ns / 100ps

module tb_rotating_color_wheel_led_effect;
   import cwl_pkg::*;

   // One LED color transaction as it leaves the block
   typedef struct packed {
      logic [IDX_W-1:0]  led_index;
      logic [BYTE_W-1:0] wire_byte0;
      logic [BYTE_W-1:0] wire_byte1;
      logic [BYTE_W-1:0] wire_byte2;
      logic              last_led;
   } led_color_type;

   // Cycles to let the block finish an event that yields no LED (dropped or empty ring)
   localparam int DRAIN_CYCLES = 8;
   // Long receiver hold-off while events keep coming
   localparam int HOLD_CYCLES = 300;
   // Longest quiet stretch: the hold-off, or a long gap plus a drain, with margin
   localparam int WATCHDOG_LIMIT = 2000;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   cwl_req_if req_if ();
   cwl_rsp_if rsp_if ();

   rotating_color_wheel_led_effect i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rsp_if    (rsp_if)
   );

   // Predicted wheel state and register copies
   logic [PHASE_W-1:0] wheel_pos    = '0;
   logic [TIME_W-1:0]  last_step_ms = '0;
   logic [CNT_W-1:0]   ring_size    = RST_RING_SIZE;
   logic               order_rgb    = 1'b0;
   logic [LVL_W-1:0]   dim_level    = RST_LEVEL;
   logic [IVL_W-1:0]   step_gap_ms  = RST_INTERVAL;

   led_color_type led_colors_due[$];
   int            mismatches  = 0;
   int            idle_cycles = 0;
   bit            gaps_on     = 1'b1;
   bit            hold_rsp    = 1'b0;

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Gap length: mostly short, now and then long
   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
   endfunction

   function automatic int level_scale(input logic [LVL_W-1:0] lvl);
      case (lvl)
         3'd0:    return 0;
         3'd1:    return 80;
         3'd2:    return 120;
         3'd3:    return 160;
         default: return 200;
      endcase
   endfunction

   // Gradient edges, saturating when the last segment runs long
   function automatic int ramp_up(input int k);
      int v;
      v = k * (255 / SEG_RG);
      return (v > 255) ? 255 : v;
   endfunction

   function automatic int ramp_down(input int k);
      int v;
      v = k * (255 / SEG_RG);
      return (v > 255) ? 0 : 255 - v;
   endfunction

   // Apply one rotation event to the predicted state and queue the frame it yields
   function automatic void step_wheel(input logic ccw, input logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] since;
      int                n, lvl, off, r, g, b;
      led_color_type     c;
      since = t - last_step_ms;
      if (since < {{(TIME_W-IVL_W){1'b0}}, step_gap_ms})
         return;
      last_step_ms = t;
      if (ccw)
         wheel_pos = (wheel_pos == PHASE_W'(WHEEL_STEPS - 1)) ? '0 : wheel_pos + 1'b1;
      else
         wheel_pos = (wheel_pos == '0) ? PHASE_W'(WHEEL_STEPS - 1) : wheel_pos - 1'b1;
      n   = (ring_size > MAX_LEDS) ? MAX_LEDS : int'(ring_size);
      lvl = level_scale(dim_level);
      for (int i = 0; i < n; i++) begin
         off = (int'(wheel_pos) + (i * WHEEL_STEPS) / n) % WHEEL_STEPS;
         if (off < SEG_RG) begin
            r = ramp_down(off);
            g = ramp_up(off);
            b = 0;
         end else if (off < SEG_GB) begin
            g = ramp_down(off - SEG_RG);
            b = ramp_up(off - SEG_RG);
            r = 0;
         end else begin
            b = ramp_down(off - SEG_GB);
            r = ramp_up(off - SEG_GB);
            g = 0;
         end
         r = (r * lvl) / 255;
         g = (g * lvl) / 255;
         b = (b * lvl) / 255;
         c.led_index  = IDX_W'(i);
         c.wire_byte0 = BYTE_W'(order_rgb ? r : g);
         c.wire_byte1 = BYTE_W'(order_rgb ? g : r);
         c.wire_byte2 = BYTE_W'(b);
         c.last_led   = (i == n - 1);
         led_colors_due.push_back(c);
      end
   endfunction

   // Offer one event until it is taken; predict on acceptance
   task automatic send_event(input logic ccw, input logic [TIME_W-1:0] t);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = gap_len();
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid    = 1'b1;
      req_if.spin_ccw = ccw;
      req_if.now_ms   = t;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      step_wheel(ccw, t);
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   // Wait for every expected LED, then for the block to go idle
   task automatic settle_frames();
      while (led_colors_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Register write while idle, mirrored into the predictor
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      settle_frames();
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_RING_SIZE:  ring_size = val[CNT_W-1:0];
         CSR_BYTE_ORDER: order_rgb = val[0];
         CSR_BRIGHTNESS: if (val[LVL_W-1:0] <= LVL_MAX) dim_level = val[LVL_W-1:0];
         CSR_INTERVAL:   step_gap_ms = val[IVL_W-1:0];
         default: ;
      endcase
   endtask

   // Reset defaults: early events dropped, phase wraps both ways
   task automatic test_reset_window();
      send_event(1'b1, 32'd0);
      send_event(1'b1, 32'd49);
      send_event(1'b1, 32'd50);
      send_event(1'b0, 32'd99);
      send_event(1'b0, 32'd100);
      send_event(1'b0, 32'd150);
      send_event(1'b1, 32'd200);
   endtask

   // Register extremes, masking, saturation, ignored levels, time wrap
   task automatic test_register_extremes();
      write_reg(CSR_INTERVAL, 16'd0);
      write_reg(CSR_RING_SIZE, 16'd0);
      send_event(1'b1, 32'd200);        // empty ring still steps
      write_reg(CSR_RING_SIZE, 16'hFFE1);
      send_event(1'b0, 32'd200);        // same time, zero interval
      write_reg(CSR_RING_SIZE, 16'h001F);
      write_reg(CSR_BYTE_ORDER, 16'd1);
      write_reg(CSR_BRIGHTNESS, 16'd0);
      send_event(1'b1, 32'd0);
      write_reg(CSR_RING_SIZE, 16'hFFE7);
      for (int lvl = 1; lvl <= 3; lvl++) begin
         write_reg(CSR_BRIGHTNESS, CSR_DAT_W'(lvl));
         send_event(lvl[0], 32'd1000 + 32'(lvl));
      end
      write_reg(CSR_BRIGHTNESS, 16'd5);  // out of range, level kept
      send_event(1'b1, 32'd2000);
      write_reg(CSR_BRIGHTNESS, 16'hFFFF);
      send_event(1'b0, 32'd2001);
      write_reg(CSR_BYTE_ORDER, 16'hFFFE);
      write_reg(CSR_BRIGHTNESS, 16'hFFFC);
      send_event(1'b1, 32'd2002);
      write_reg(CSR_INTERVAL, 16'hFFFF);
      send_event(1'b1, 32'hFFFF_0000);
      send_event(1'b0, 32'hFFFF_FFFE);  // one short
      send_event(1'b0, 32'hFFFF_FFFF);  // exactly on the interval
      send_event(1'b1, 32'h0000_FFFD);  // across the wrap, one short
      send_event(1'b1, 32'h0000_FFFE);  // across the wrap, on the interval
   endtask

   // Receiver holds off while events keep coming, so the block backs up
   task automatic test_output_stall();
      write_reg(CSR_RING_SIZE, 16'd16);
      write_reg(CSR_INTERVAL, 16'd0);
      hold_rsp = 1'b1;
      for (int k = 0; k < 12; k++)
         send_event(1'($urandom_range(0, 1)), $urandom());
   endtask

   // Random settings per phase; mostly well-spaced events, some early, some noise
   task automatic test_random_phases();
      logic [CSR_DAT_W-1:0] val;
      logic [TIME_W-1:0]    t;
      int                   pick;
      for (int p = 0; p < 8; p++) begin
         gaps_on = (p != 5);
         val = CSR_DAT_W'($urandom());
         pick = $urandom_range(0, 9);
         val[CNT_W-1:0] = (pick == 0) ? 5'd0 :
                          (pick == 1) ? CNT_W'($urandom_range(17, 31)) :
                                        CNT_W'($urandom_range(1, 16));
         write_reg(CSR_RING_SIZE, val);
         write_reg(CSR_BYTE_ORDER, CSR_DAT_W'($urandom()));
         write_reg(CSR_BRIGHTNESS, CSR_DAT_W'($urandom()));
         case ($urandom_range(0, 7))
            0:       val = 16'd0;
            1:       val = 16'hFFFF;
            2, 3:    val = CSR_DAT_W'($urandom());
            default: val = CSR_DAT_W'($urandom_range(1, 40));
         endcase
         write_reg(CSR_INTERVAL, val);
         for (int k = 0; k < 45; k++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               t = $urandom();
            else if (pick <= 2 && step_gap_ms != 0)
               t = last_step_ms + TIME_W'($urandom_range(0, int'(step_gap_ms) - 1));
            else
               t = last_step_ms + TIME_W'(step_gap_ms) + TIME_W'($urandom_range(0, 30));
            send_event(1'($urandom_range(0, 1)), t);
         end
      end
      gaps_on = 1'b1;
   endtask

   // Receiver ready: random gaps, or one long hold-off on request
   initial begin : rsp_ready_gen
      int gap;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_if.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp     = 1'b0;
            rsp_if.ready = 1'b1;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = gap_len();
            rsp_if.ready = 1'b0;
            repeat (gap) @(negedge clock);
            rsp_if.ready = 1'b1;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   // Compare each LED transaction with the oldest prediction
   always @(posedge clock) begin : color_check
      led_color_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (led_colors_due.size() == 0) begin
            $error("unexpected LED transaction: led_index %0d", rsp_if.led_index);
            mismatches++;
         end else begin
            want = led_colors_due.pop_front();
            if (rsp_if.led_index !== want.led_index) begin
               $error("led_index: expected %0d, got %0d", want.led_index, rsp_if.led_index);
               mismatches++;
            end
            if (rsp_if.wire_byte0 !== want.wire_byte0) begin
               $error("wire_byte0: expected %0d, got %0d", want.wire_byte0, rsp_if.wire_byte0);
               mismatches++;
            end
            if (rsp_if.wire_byte1 !== want.wire_byte1) begin
               $error("wire_byte1: expected %0d, got %0d", want.wire_byte1, rsp_if.wire_byte1);
               mismatches++;
            end
            if (rsp_if.wire_byte2 !== want.wire_byte2) begin
               $error("wire_byte2: expected %0d, got %0d", want.wire_byte2, rsp_if.wire_byte2);
               mismatches++;
            end
            if (rsp_if.last_led !== want.last_led) begin
               $error("last_led: expected %0d, got %0d", want.last_led, rsp_if.last_led);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Test sequence
   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_if.valid    = 1'b0;
      req_if.spin_ccw = 1'b0;
      req_if.now_ms   = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_reset_window();
      test_register_extremes();
      test_output_stall();
      test_random_phases();

      settle_frames();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && led_colors_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
